// ----- rtl/bwa_pkg.sv -----
// shared types and constants of the beacon rssi window averager
`default_nettype none

package bwa_pkg;

   // field widths fixed by the transaction format
   localparam int ADDR_W = 48;
   localparam int RSSI_W = 8;
   localparam int CNT_W  = 4;
   localparam int SUM_W  = 12;
   localparam int MAG_W  = 11;
   localparam int STEP_W = 4;

   // configuration register indexes
   localparam logic REG_MIN_SAMPLES = 1'b0;
   localparam logic REG_MAX_SAMPLES = 1'b1;

   // configuration reset values
   localparam logic [CNT_W-1:0] MIN_SAMPLES_RST = 4'd3;
   localparam logic [CNT_W-1:0] MAX_SAMPLES_RST = 4'd10;

   // one table entry
   typedef struct packed {
      logic [ADDR_W-1:0]       addr;
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
   } entry_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
      logic wr_upd;
      logic wr_new;
      logic used_clr;
      logic div_start;
      logic pend_set;
      logic out_load;
      logic out_last;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic idx_at_used;
      logic full;
      logic hit;
      logic can_add;
      logic qualifies;
      logic pend_valid;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/bwa_div.sv -----
// iterative restoring divider: window sum over sample count, truncated toward zero
`default_nettype none

module bwa_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [bwa_pkg::SUM_W-1:0]  dividend,
   input  wire logic [bwa_pkg::CNT_W-1:0]         divisor,
   output logic                                   done,
   output logic signed [bwa_pkg::RSSI_W-1:0]      quotient
);
   import bwa_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;

   logic [SUM_W-1:0]  abs_val;
   logic [CNT_W:0]    trial;
   logic              fits;
   logic [MAG_W-1:0]  signed_q;

   // magnitude of the dividend and one quotient bit per cycle
   always_comb begin
      abs_val = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      trial   = {rem_ff, quo_ff[MAG_W-1]};
      fits    = trial >= {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(MAG_W);
         rem_in  = '0;
         quo_in  = abs_val[MAG_W-1:0];
         den_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         zero_in = divisor == '0;
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, den_ff}) : trial[CNT_W-1:0];
         quo_in  = {quo_ff[MAG_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         busy_in = step_ff != STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // sign restore; a zero count averages to zero
   assign signed_q = neg_ff ? (~quo_ff + MAG_W'(1)) : quo_ff;
   assign quotient = zero_ff ? '0 : signed_q[RSSI_W-1:0];
   assign done     = busy_ff && (step_ff == STEP_W'(1));

endmodule

`default_nettype wire

// ----- rtl/bwa_ctrl.sv -----
// controller state machine: table search, insertion and window close sequencing
`default_nettype none

module bwa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic               req_target_match,
   input  wire bwa_pkg::stat_type  stat,
   output bwa_pkg::cmd_type        cmd
);
   import bwa_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SRCH_RD  = 7'b0000010,
      S_SRCH_CMP = 7'b0000100,
      S_CLS_RD   = 7'b0001000,
      S_CLS_CHK  = 7'b0010000,
      S_CLS_DIV  = 7'b0100000,
      S_CLS_END  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_action) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_CLS_RD;
               end else if (req_target_match) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_SRCH_RD;
               end
            end
         end
         S_SRCH_RD: begin
            if (stat.idx_at_used) begin
               cmd.wr_new = !stat.full;
               state_in   = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (stat.hit) begin
               cmd.wr_upd = stat.can_add;
               state_in   = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_CLS_RD: begin
            if (stat.idx_at_used) begin
               state_in = S_CLS_END;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CLS_CHK;
            end
         end
         S_CLS_CHK: begin
            // a held result goes out before the next divide overwrites it
            if (!stat.qualifies) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_CLS_RD;
            end else if (!stat.pend_valid) begin
               cmd.div_start = 1'b1;
               state_in      = S_CLS_DIV;
            end else if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_CLS_DIV;
            end
         end
         S_CLS_DIV: begin
            if (stat.div_done) begin
               cmd.pend_set = 1'b1;
               cmd.idx_inc  = 1'b1;
               state_in     = S_CLS_RD;
            end
         end
         S_CLS_END: begin
            // final result carries last, then the table empties
            if (!stat.pend_valid) begin
               cmd.used_clr = 1'b1;
               state_in     = S_IDLE;
            end else if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               cmd.used_clr = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

`default_nettype wire

// ----- rtl/bwa_dpath.sv -----
// datapath: configuration, entry memory, pending result, divider and result register
`default_nettype none

module bwa_dpath #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bwa_pkg::cmd_type                  cmd,
   output bwa_pkg::stat_type                      stat,
   input  wire logic [bwa_pkg::ADDR_W-1:0]        req_address,
   input  wire logic signed [bwa_pkg::RSSI_W-1:0] req_rssi,
   input  wire logic                              csr_write,
   input  wire logic                              csr_index,
   input  wire logic [bwa_pkg::CNT_W-1:0]         csr_wdata,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bwa_pkg::ADDR_W-1:0]             rsp_device_address,
   output logic signed [bwa_pkg::RSSI_W-1:0]      rsp_mean_rssi,
   output logic [bwa_pkg::CNT_W-1:0]              rsp_sample_count,
   output logic                                   rsp_last
);
   import bwa_pkg::*;

   localparam int USED_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [CNT_W-1:0]        min_ff, min_in;
   logic [CNT_W-1:0]        max_ff, max_in;
   logic [USED_W-1:0]       used_ff, used_in;
   logic [USED_W-1:0]       idx_ff, idx_in;
   logic [ADDR_W-1:0]       cap_addr_ff;
   logic signed [RSSI_W-1:0] cap_rssi_ff;

   entry_type               entry_ff [TABLE_DEPTH];
   entry_type               rd_ff;
   entry_type               wr_data;
   logic                    wr_en;
   logic [IDX_W-1:0]        mem_idx;
   logic signed [SUM_W-1:0] rssi_ext;

   logic                    pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]       pend_addr_ff;
   logic [CNT_W-1:0]        pend_count_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_addr_ff;
   logic signed [RSSI_W-1:0] rsp_avg_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic                    rsp_last_ff;

   logic                    div_done;
   logic signed [RSSI_W-1:0] div_quotient;
   logic                    out_free;

   // configuration registers
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (csr_write) begin
         case (csr_index)
            REG_MIN_SAMPLES: min_in = csr_wdata;
            REG_MAX_SAMPLES: max_in = csr_wdata;
            default: begin
               min_in = min_ff;
            end
         endcase
      end
   end

   // table fill count and scan index
   always_comb begin
      used_in = used_ff;
      if (cmd.used_clr) begin
         used_in = '0;
      end else if (cmd.wr_new) begin
         used_in = used_ff + USED_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + USED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MIN_SAMPLES_RST;
         max_ff  <= MAX_SAMPLES_RST;
         used_ff <= '0;
         idx_ff  <= '0;
      end else begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         used_ff <= used_in;
         idx_ff  <= idx_in;
      end
   end

   // captured report
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_addr_ff <= req_address;
         cap_rssi_ff <= req_rssi;
      end
   end

   // entry write data: update of a found entry or a fresh entry
   assign rssi_ext = {{(SUM_W-RSSI_W){cap_rssi_ff[RSSI_W-1]}}, cap_rssi_ff};
   assign mem_idx  = idx_ff[IDX_W-1:0];
   assign wr_en    = cmd.wr_upd || cmd.wr_new;

   always_comb begin
      if (cmd.wr_new) begin
         wr_data.addr  = cap_addr_ff;
         wr_data.sum   = (max_ff != '0) ? rssi_ext : '0;
         wr_data.count = (max_ff != '0) ? CNT_W'(1) : '0;
      end else begin
         wr_data.addr  = rd_ff.addr;
         wr_data.sum   = rd_ff.sum + rssi_ext;
         wr_data.count = rd_ff.count + CNT_W'(1);
      end
   end

   // entry memory, one port at the scan index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[mem_idx] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= entry_ff[mem_idx];
      end
   end

   bwa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_ff.sum),
      .divisor  (rd_ff.count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // pending result, held until the next qualifying entry or the window end
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.pend_set) begin
         pend_valid_in = 1'b1;
      end else if (cmd.out_load) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         pend_addr_ff  <= rd_ff.addr;
         pend_count_ff <= rd_ff.count;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_addr_ff  <= pend_addr_ff;
         rsp_avg_ff   <= div_quotient;
         rsp_count_ff <= pend_count_ff;
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_device_address = rsp_addr_ff;
   assign rsp_mean_rssi      = rsp_avg_ff;
   assign rsp_sample_count   = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

   // status to the controller
   always_comb begin
      stat.idx_at_used = idx_ff == used_ff;
      stat.full        = used_ff == USED_W'(TABLE_DEPTH);
      stat.hit         = rd_ff.addr == cap_addr_ff;
      stat.can_add     = rd_ff.count < max_ff;
      stat.qualifies   = rd_ff.count >= min_ff;
      stat.pend_valid  = pend_valid_ff;
      stat.div_done    = div_done;
      stat.out_free    = out_free;
   end

endmodule

`default_nettype wire

// ----- rtl/beacon_rssi_window_averager.sv -----
// Report transaction: each entry searched is read, then compared with the address;
// a new address is written once the scan reaches the fill count and the table is not full.
// Window close: each entry is read and checked; each reported device goes through the
// divider, one quotient bit per cycle, and results wait while the result side stalls.
// One transaction at a time; the next is taken once the current one has finished.
// Reset: min_samples 3, max_samples 10, table empty (fill count zeroed, no clearing pass).
// Top level of the beacon rssi window averager
`default_nettype none

module beacon_rssi_window_averager #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_action,
   input  wire logic [bwa_pkg::ADDR_W-1:0]        req_address,
   input  wire logic signed [bwa_pkg::RSSI_W-1:0] req_rssi,
   input  wire logic                              req_target_match,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bwa_pkg::ADDR_W-1:0]             rsp_device_address,
   output logic signed [bwa_pkg::RSSI_W-1:0]      rsp_mean_rssi,
   output logic [bwa_pkg::CNT_W-1:0]              rsp_sample_count,
   output logic                                   rsp_last,
   input  wire logic                              csr_write,
   input  wire logic                              csr_index,
   input  wire logic [bwa_pkg::CNT_W-1:0]         csr_wdata
);
   import bwa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   bwa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_target_match (req_target_match),
      .stat             (stat),
      .cmd              (cmd)
   );

   // storage and arithmetic
   bwa_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_address        (req_address),
      .req_rssi           (req_rssi),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_device_address (rsp_device_address),
      .rsp_mean_rssi      (rsp_mean_rssi),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire
